@@ hdl/tmc_pkg.sv @@
// ----------------------------------------------------------------------------
// tmc_pkg
// shared constants, types and the cordic arctangent table for the
// transform matrix composer
// ----------------------------------------------------------------------------
package tmc_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int ELEM_W         = 32;
    localparam int ANGLE_W        = 16;
    localparam int MAT_DEPTH      = 16;
    localparam int MAT_AW         = $clog2(MAT_DEPTH);
    localparam int CORDIC_ITERS   = 28;
    localparam int CORDIC_IW      = $clog2(CORDIC_ITERS);
    localparam int CORDIC_W       = 34;
    localparam int CORDIC_ZW      = 33;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032875;

    typedef enum logic [1:0] {
        REQ_IDENT  = 2'd0,
        REQ_TRANS  = 2'd1,
        REQ_SCALE  = 2'd2,
        REQ_ROTATE = 2'd3
    } t_req;

    // sine and cosine handed from the cordic unit to the sequencer
    typedef struct packed {
        logic                     done;
        logic signed [ELEM_W-1:0] sin_v;
        logic signed [ELEM_W-1:0] cos_v;
    } t_trig;

    // arctangent of 2^-i as a fraction of a turn scaled by 2^32
    function automatic logic [31:0] atan_turn(input logic [CORDIC_IW-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/tmc_ram.sv @@
// ----------------------------------------------------------------------------
// tmc_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module tmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

@@ hdl/tmc_cordic.sv @@
// ----------------------------------------------------------------------------
// tmc_cordic
// iterative rotation-mode cordic, one micro-rotation per cycle, returns
// sine and cosine of a binary angle rounded to the element format
// ----------------------------------------------------------------------------
module tmc_cordic import tmc_pkg::*; #(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [ANGLE_W-1:0] i_angle,
    output t_trig              o_trig
);

    localparam int ASH = 32 - ANGLE_BITS;
    localparam int RSH = 30 - FRAC_BITS;
    localparam logic signed [CORDIC_W:0] RHALF = (CORDIC_W+1)'(64'(1) << (RSH - 1));
    localparam logic signed [CORDIC_W:0] RONE  = (CORDIC_W+1)'(64'(1) << FRAC_BITS);

    logic                        r_busy;
    logic                        r_fin;
    logic [CORDIC_IW-1:0]        r_iter;
    logic signed [CORDIC_W-1:0]  r_x;
    logic signed [CORDIC_W-1:0]  r_y;
    logic signed [CORDIC_ZW-1:0] r_z;
    logic [1:0]                  r_q;
    t_trig                       r_out;

    logic [31:0]                 a_turn;
    logic [31:0]                 a_off;
    logic [31:0]                 a_red;
    logic signed [CORDIC_W-1:0]  dx;
    logic signed [CORDIC_W-1:0]  dy;
    logic signed [CORDIC_ZW-1:0] dz;
    logic signed [CORDIC_W-1:0]  c_raw;
    logic signed [CORDIC_W-1:0]  s_raw;

    function automatic logic signed [ELEM_W-1:0] to_elem(input logic signed [CORDIC_W-1:0] v);
        logic signed [CORDIC_W:0] t;
        t = ($signed({v[CORDIC_W-1], v}) + RHALF) >>> RSH;
        if (t > RONE) begin
            t = RONE;
        end else if (t < -RONE) begin
            t = -RONE;
        end
        return t[ELEM_W-1:0];
    endfunction

    // fold the angle into the quarter turn around zero
    assign a_turn = {16'b0, i_angle} << ASH;
    assign a_off  = a_turn + 32'h2000_0000;
    assign a_red  = a_turn - {a_off[31:30], 30'b0};

    assign dx = r_y >>> r_iter;
    assign dy = r_x >>> r_iter;
    assign dz = $signed({1'b0, atan_turn(r_iter)});

    always_comb begin
        unique case (r_q)
            2'd0: begin c_raw = r_x;  s_raw = r_y;  end
            2'd1: begin c_raw = -r_y; s_raw = r_x;  end
            2'd2: begin c_raw = -r_x; s_raw = -r_y; end
            2'd3: begin c_raw = r_y;  s_raw = -r_x; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_fin      <= 1'b0;
            r_iter     <= '0;
            r_out.done <= 1'b0;
        end else begin
            r_out.done <= 1'b0;
            r_fin      <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_iter <= '0;
                r_x    <= CORDIC_GAIN;
                r_y    <= '0;
                r_z    <= $signed({a_red[31], a_red});
                r_q    <= a_off[31:30];
            end else if (r_busy) begin
                if (!r_z[CORDIC_ZW-1]) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - dz;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + dz;
                end
                if (r_iter == CORDIC_IW'(CORDIC_ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end else begin
                    r_iter <= r_iter + 1'b1;
                end
            end
            if (r_fin) begin
                r_out.done  <= 1'b1;
                r_out.sin_v <= to_elem(s_raw);
                r_out.cos_v <= to_elem(c_raw);
            end
        end
    end

    assign o_trig = r_out;

endmodule

@@ hdl/transform_matrix_composer.sv @@
// ----------------------------------------------------------------------------
// transform_matrix_composer
// keeps one 4x4 transform matrix and applies identity, translate, scale or
// rotate, then streams the 16 elements row by row
// ----------------------------------------------------------------------------
// The matrix lives in a 16-entry ram. After reset a pass loads the
// identity before the first item is taken. One item is worked at a time:
// every changed element is one read-modify-write through a single shared
// 32x32 multiplier (four products per row step) and the one write port, and
// each rotation axis first waits for the 28-step cordic. Every request, identity
// included, ends with 16 output beats, which the output side may stall.
module transform_matrix_composer import tmc_pkg::*; #(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_req_type,
    input  logic signed [ELEM_W-1:0] i_trans_x,
    input  logic signed [ELEM_W-1:0] i_trans_y,
    input  logic signed [ELEM_W-1:0] i_trans_z,
    input  logic signed [ELEM_W-1:0] i_scale_factor,
    input  logic [ANGLE_W-1:0]       i_angle_x,
    input  logic [ANGLE_W-1:0]       i_angle_y,
    input  logic [ANGLE_W-1:0]       i_angle_z,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [1:0]               o_row_index,
    output logic [1:0]               o_col_index,
    output logic signed [ELEM_W-1:0] o_element_value,
    output logic                     o_last_element
);

    localparam int ACC_W = 2 * ELEM_W + 1;
    localparam logic signed [ELEM_W-1:0] ONE  = ELEM_W'(64'(1) << FRAC_BITS);
    localparam logic signed [ACC_W-1:0]  HALF = ACC_W'(80'(1) << (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0]  ACC_MAX =
        {{(ACC_W-ELEM_W+1){1'b0}}, {(ELEM_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0]  ACC_MIN =
        {{(ACC_W-ELEM_W+1){1'b1}}, {(ELEM_W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDENT, S_IDLE, S_CSTART, S_CWAIT, S_RD, S_LAT, S_MUL,
        S_WR1, S_WR2, S_EMIT_RD, S_EMIT_LD, S_EMIT_WAIT
    } t_state;

    typedef enum logic [2:0] {
        P_TRANS, P_SCALE, P_ROTY, P_ROTX, P_ROTZ
    } t_pass;

    t_state                     r_state;
    t_pass                      r_pass;
    logic                       r_init;
    logic [MAT_AW-1:0]          r_idx;
    logic [1:0]                 r_row;
    logic [1:0]                 r_sub;
    logic [2:0]                 r_k;
    logic signed [ELEM_W-1:0]   r_tx, r_ty, r_tz, r_sf;
    logic [ANGLE_W-1:0]         r_ax, r_ay, r_az;
    logic signed [ELEM_W-1:0]   r_sin, r_cos;
    logic signed [ELEM_W-1:0]   r_a, r_b;
    logic signed [2*ELEM_W-1:0] r_prod;
    logic signed [ACC_W-1:0]    r_acc1, r_acc2;
    logic                       r_ovalid;
    logic [MAT_AW-1:0]          r_oidx;
    logic signed [ELEM_W-1:0]   r_oval;

    logic [1:0]                 ja, jb;
    logic signed [ELEM_W-1:0]   c1, c2, c3, c4;
    logic                       wr2;
    logic signed [ELEM_W-1:0]   mul_x, mul_c;
    logic signed [2*ELEM_W-1:0] mul_p;
    logic                       we;
    logic [MAT_AW-1:0]          waddr, raddr_a, raddr_b;
    logic [ELEM_W-1:0]          wdata, rd_a, rd_b;
    logic [ANGLE_W-1:0]         c_angle;
    logic                       o_fire;
    logic                       sub_last;
    t_trig                      trig;

    function automatic logic signed [ELEM_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] t;
        t = (acc + HALF) >>> FRAC_BITS;
        if (t > ACC_MAX) begin
            t = ACC_MAX;
        end else if (t < ACC_MIN) begin
            t = ACC_MIN;
        end
        return t[ELEM_W-1:0];
    endfunction

    // column pair and coefficients of one row step of the current pass
    always_comb begin
        ja  = r_sub;
        jb  = 2'd3;
        c1  = ONE;
        c2  = '0;
        c3  = '0;
        c4  = '0;
        wr2 = 1'b0;
        unique case (r_pass)
            P_TRANS: begin
                unique case (r_sub)
                    2'd0:    c2 = r_tx;
                    2'd1:    c2 = r_ty;
                    default: c2 = r_tz;
                endcase
            end
            P_SCALE: begin
                c1 = r_sf;
            end
            P_ROTY: begin
                ja = 2'd0; jb = 2'd2; wr2 = 1'b1;
                c1 = r_cos; c2 = r_sin; c3 = -r_sin; c4 = r_cos;
            end
            P_ROTX: begin
                ja = 2'd1; jb = 2'd2; wr2 = 1'b1;
                c1 = r_cos; c2 = -r_sin; c3 = r_sin; c4 = r_cos;
            end
            P_ROTZ: begin
                ja = 2'd0; jb = 2'd1; wr2 = 1'b1;
                c1 = r_cos; c2 = -r_sin; c3 = r_sin; c4 = r_cos;
            end
            default: begin
                ja = r_sub;
            end
        endcase
    end

    assign sub_last = (r_pass != P_TRANS && r_pass != P_SCALE) || (r_sub == 2'd2);

    always_comb begin
        unique case (r_k)
            3'd0:    begin mul_x = r_a; mul_c = c1; end
            3'd1:    begin mul_x = r_b; mul_c = c2; end
            3'd2:    begin mul_x = r_a; mul_c = c3; end
            default: begin mul_x = r_b; mul_c = c4; end
        endcase
    end

    assign mul_p = mul_x * mul_c;

    assign o_fire = r_ovalid && i_out_ready;

    always_comb begin
        priority if (r_state == S_EMIT_WAIT && o_fire) begin
            raddr_a = r_oidx + 1'b1;
        end else if (r_state == S_EMIT_RD || r_state == S_EMIT_LD
                     || r_state == S_EMIT_WAIT) begin
            raddr_a = r_oidx;
        end else begin
            raddr_a = {r_row, ja};
        end
    end

    assign raddr_b = {r_row, jb};

    always_comb begin
        we    = 1'b0;
        waddr = {r_row, ja};
        wdata = round_sat(r_acc1);
        unique case (r_state)
            S_IDENT: begin
                we    = 1'b1;
                waddr = r_idx;
                wdata = (r_idx[1:0] == r_idx[3:2]) ? ONE : '0;
            end
            S_WR1: begin
                we = 1'b1;
            end
            S_WR2: begin
                we    = 1'b1;
                waddr = {r_row, jb};
                wdata = round_sat(r_acc2);
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_comb begin
        unique case (r_pass)
            P_ROTX:  c_angle = r_ax;
            P_ROTZ:  c_angle = r_az;
            default: c_angle = r_ay;
        endcase
    end

    tmc_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAT_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .o_rdata_a (rd_a),
        .i_raddr_b (raddr_b),
        .o_rdata_b (rd_b)
    );

    tmc_cordic #(
        .FRAC_BITS  (FRAC_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_CSTART),
        .i_angle (c_angle),
        .o_trig  (trig)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDENT;
            r_init   <= 1'b1;
            r_idx    <= '0;
            r_row    <= '0;
            r_sub    <= '0;
            r_k      <= '0;
            r_pass   <= P_TRANS;
            r_ovalid <= 1'b0;
            r_oidx   <= '0;
        end else begin
            unique case (r_state)
                S_IDENT: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == MAT_AW'(MAT_DEPTH - 1)) begin
                        r_state <= r_init ? S_IDLE : S_EMIT_RD;
                        r_init  <= 1'b0;
                        r_oidx  <= '0;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_tx  <= i_trans_x;
                        r_ty  <= i_trans_y;
                        r_tz  <= i_trans_z;
                        r_sf  <= i_scale_factor;
                        r_ax  <= i_angle_x;
                        r_ay  <= i_angle_y;
                        r_az  <= i_angle_z;
                        r_row <= '0;
                        r_sub <= '0;
                        r_idx <= '0;
                        unique case (t_req'(i_req_type))
                            REQ_IDENT: r_state <= S_IDENT;
                            REQ_TRANS: begin
                                r_pass  <= P_TRANS;
                                r_state <= S_RD;
                            end
                            REQ_SCALE: begin
                                r_pass  <= P_SCALE;
                                r_state <= S_RD;
                            end
                            REQ_ROTATE: begin
                                r_pass  <= P_ROTY;
                                r_state <= S_CSTART;
                            end
                        endcase
                    end
                end
                S_CSTART: begin
                    r_state <= S_CWAIT;
                end
                S_CWAIT: begin
                    if (trig.done) begin
                        r_sin   <= trig.sin_v;
                        r_cos   <= trig.cos_v;
                        r_row   <= '0;
                        r_sub   <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_LAT;
                end
                S_LAT: begin
                    r_a     <= rd_a;
                    r_b     <= rd_b;
                    r_k     <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod <= mul_p;
                    unique case (r_k)
                        3'd1:    r_acc1 <= ACC_W'(r_prod);
                        3'd2:    r_acc1 <= r_acc1 + ACC_W'(r_prod);
                        3'd3:    r_acc2 <= ACC_W'(r_prod);
                        3'd4:    r_acc2 <= r_acc2 + ACC_W'(r_prod);
                        default: r_acc1 <= r_acc1;
                    endcase
                    if (r_k == 3'd4) begin
                        r_state <= S_WR1;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_WR1, S_WR2: begin
                    priority if (r_state == S_WR1 && wr2) begin
                        r_state <= S_WR2;
                    end else if (!sub_last) begin
                        r_sub   <= r_sub + 1'b1;
                        r_state <= S_RD;
                    end else if (r_row != 2'd3) begin
                        r_sub   <= '0;
                        r_row   <= r_row + 1'b1;
                        r_state <= S_RD;
                    end else begin
                        r_sub <= '0;
                        r_row <= '0;
                        priority if (r_pass == P_ROTY) begin
                            r_pass  <= P_ROTX;
                            r_state <= S_CSTART;
                        end else if (r_pass == P_ROTX) begin
                            r_pass  <= P_ROTZ;
                            r_state <= S_CSTART;
                        end else begin
                            r_oidx  <= '0;
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_LD;
                end
                S_EMIT_LD: begin
                    r_oval   <= rd_a;
                    r_ovalid <= 1'b1;
                    r_state  <= S_EMIT_WAIT;
                end
                S_EMIT_WAIT: begin
                    if (o_fire) begin
                        r_ovalid <= 1'b0;
                        r_oidx   <= r_oidx + 1'b1;
                        r_state  <= (r_oidx == MAT_AW'(MAT_DEPTH - 1)) ? S_IDLE : S_EMIT_LD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_ovalid;
    assign o_row_index     = r_oidx[3:2];
    assign o_col_index     = r_oidx[1:0];
    assign o_element_value = r_oval;
    assign o_last_element  = (r_oidx == MAT_AW'(MAT_DEPTH - 1));

endmodule

@@ hdl/tmc_checker.sv @@
// ----------------------------------------------------------------------------
// tmc_checker
// port-level checks of the transform matrix composer, bound to the top level
// ----------------------------------------------------------------------------
module tmc_checker import tmc_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic [1:0]               o_row_index,
    input logic [1:0]               o_col_index,
    input logic signed [ELEM_W-1:0] o_element_value,
    input logic                     o_last_element
);

    // last beat only at the bottom right element
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_element |-> o_row_index == 2'd3 && o_col_index == 2'd3)
        else $error("last beat not at bottom right element");

    // no new item while results are still going out
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while output beat pending");

    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready && !o_out_valid)
        else $error("block not busy after accepting an item");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_last_element |=> !o_out_valid)
        else $error("beat after last element");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_element_value))
        else $error("stalled output beat changed");

endmodule

bind transform_matrix_composer tmc_checker u_tmc_checker (.*);
